[sv/jets_pkg.sv]
// Shared constants, types and helper functions for the Julia escape-time pixel unit.
`timescale 1ns / 1ps
`default_nettype none

package jets_pkg;

  // Image geometry and fixed-point format.
  localparam int unsigned IMAGE_WIDTH    = 1024;
  localparam int unsigned IMAGE_HEIGHT   = 1024;
  localparam int unsigned FRAC_BITS      = 28;
  localparam int unsigned ITER_BOUND_DEF = 64;

  // Field widths.
  localparam int unsigned PIX_W     = 11;
  localparam int unsigned VAL_W     = 32;
  localparam int unsigned STEP_W    = 31;
  localparam int unsigned RSQ_W     = 32;
  localparam int unsigned MAXIT_W   = 7;
  localparam int unsigned COUNT_W   = 6;
  localparam int unsigned COLOR_W   = 24;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DAT_W = 32;
  localparam int unsigned PAL_IDX_W = 4;

  // Derived widths for coordinates, products and the escape compare.
  localparam int unsigned IMAGE_MAX = (IMAGE_WIDTH > IMAGE_HEIGHT) ? IMAGE_WIDTH : IMAGE_HEIGHT;
  localparam int unsigned COORD_W   = ($clog2(IMAGE_MAX + 1) > PIX_W) ?
                                      $clog2(IMAGE_MAX + 1) : PIX_W;
  localparam int unsigned OFFS_W    = COORD_W + STEP_W;
  localparam int unsigned PROD_W    = 2 * VAL_W;
  localparam int unsigned THR_W     = RSQ_W + FRAC_BITS;
  localparam int unsigned CMP_W     = (THR_W > PROD_W) ? THR_W : PROD_W;

  // Register reset values.
  localparam logic [VAL_W-1:0]   START_RESET  = 32'hE000_0000;
  localparam logic [STEP_W-1:0]  STEP_RESET   = 31'd1048576;
  localparam logic [RSQ_W-1:0]   RADIUS_RESET = 32'h4000_0000;
  localparam logic [MAXIT_W-1:0] MAXIT_RESET  = 7'd50;

  // Configuration register map.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_START_REAL = 3'd0,
    REG_START_IMAG = 3'd1,
    REG_STEP_REAL  = 3'd2,
    REG_STEP_IMAG  = 3'd3,
    REG_CONST_REAL = 3'd4,
    REG_CONST_IMAG = 3'd5,
    REG_RADIUS_SQ  = 3'd6,
    REG_MAX_ITER   = 3'd7
  } jets_reg_e;

  // Per-pixel control that travels with the iterate.
  typedef struct packed {
    logic               valid;
    logic               done;
    logic               escaped;
    logic [COUNT_W-1:0] count;
  } jets_ctl_t;

  // Saturate a wide signed value to the 32-bit signed range.
  function automatic logic signed [VAL_W-1:0] sat_val(input logic signed [PROD_W-1:0] v);
    logic fits;
    fits = (&v[PROD_W-1:VAL_W-1]) || !(|v[PROD_W-1:VAL_W-1]);
    if (fits) begin
      return v[VAL_W-1:0];
    end else if (v[PROD_W-1]) begin
      return {1'b1, {(VAL_W-1){1'b0}}};
    end else begin
      return {1'b0, {(VAL_W-1){1'b1}}};
    end
  endfunction

  // Sixteen-entry color table indexed by the escape count.
  function automatic logic [COLOR_W-1:0] palette_color(input logic [PAL_IDX_W-1:0] idx);
    logic [COLOR_W-1:0] c;
    case (idx)
      4'd0:    c = 24'h42200F;
      4'd1:    c = 24'h19071A;
      4'd2:    c = 24'h09012F;
      4'd3:    c = 24'h040449;
      4'd4:    c = 24'h000764;
      4'd5:    c = 24'h0C2C8A;
      4'd6:    c = 24'h1852B1;
      4'd7:    c = 24'h397DD1;
      4'd8:    c = 24'h86B5E5;
      4'd9:    c = 24'hD3ECF8;
      4'd10:   c = 24'hF1E9BF;
      4'd11:   c = 24'hF8C95F;
      4'd12:   c = 24'hFFAA00;
      4'd13:   c = 24'hCC8000;
      4'd14:   c = 24'h995700;
      default: c = 24'h6A3403;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

[sv/jets_if.sv]
// Handshake channel interfaces for pixels in, colors out and configuration writes.
`timescale 1ns / 1ps
`default_nettype none

interface jets_pixel_if import jets_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_x;
  logic [PIX_W-1:0] pixel_y;

  modport source (output valid, output pixel_x, output pixel_y, input ready);
  modport sink   (input valid, input pixel_x, input pixel_y, output ready);
endinterface

interface jets_color_if import jets_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [COLOR_W-1:0] pixel_color;
  logic               escaped;
  logic [COUNT_W-1:0] escape_count;

  modport source (output valid, output pixel_color, output escaped, output escape_count,
                  input ready);
  modport sink   (input valid, input pixel_color, input escaped, input escape_count,
                  output ready);
endinterface

interface jets_cfg_if import jets_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_DAT_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

[sv/jets_iter.sv]
// One unrolled iteration of z = z*z + c with the escape and limit tests, two register stages.
`timescale 1ns / 1ps
`default_nettype none

module jets_iter import jets_pkg::*; #(
  parameter int unsigned STAGE_IDX = 0,
  parameter int unsigned LIM_W     = 7
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    en_i,
  input  wire jets_ctl_t               ctl_i,
  input  wire logic signed [VAL_W-1:0] zr_i,
  input  wire logic signed [VAL_W-1:0] zi_i,
  input  wire logic signed [VAL_W-1:0] const_real_i,
  input  wire logic signed [VAL_W-1:0] const_imag_i,
  input  wire logic [RSQ_W-1:0]        radius_sq_i,
  input  wire logic [LIM_W-1:0]        lim_i,
  output jets_ctl_t                    ctl_o,
  output logic signed [VAL_W-1:0]      zr_o,
  output logic signed [VAL_W-1:0]      zi_o
);

  localparam logic [LIM_W-1:0]   IDX_LIM   = LIM_W'(STAGE_IDX);
  localparam logic [COUNT_W-1:0] IDX_COUNT = COUNT_W'(STAGE_IDX);

  jets_ctl_t                  ctl_a_d, ctl_a_q;
  jets_ctl_t                  ctl_b_d, ctl_b_q;
  logic signed [PROD_W-1:0]   rr_d, ii_d, ri_d;
  logic signed [PROD_W-1:0]   rr_q, ii_q, ri_q;
  logic [PROD_W-1:0]          mag;
  logic [THR_W-1:0]           thr;
  logic                       outside;
  logic signed [PROD_W-1:0]   nr_full, ni_full;
  logic signed [VAL_W-1:0]    zr_d, zi_d, zr_q, zi_q;

  // Stage A: the three products, and the iteration limit ends the pixel before its test.
  assign rr_d = zr_i * zr_i;
  assign ii_d = zi_i * zi_i;
  assign ri_d = zr_i * zi_i;

  always_comb begin
    ctl_a_d = ctl_i;
    if (!ctl_i.done && (IDX_LIM >= lim_i)) begin
      ctl_a_d.done = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_a_q <= '0;
    end else if (en_i) begin
      ctl_a_q <= ctl_a_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rr_q <= rr_d;
      ii_q <= ii_d;
      ri_q <= ri_d;
    end
  end

  // Stage B: exact magnitude test against the scaled radius, then the next iterate.
  assign mag     = $unsigned(rr_q) + $unsigned(ii_q);
  assign thr     = {radius_sq_i, {FRAC_BITS{1'b0}}};
  assign outside = CMP_W'(mag) > CMP_W'(thr);
  assign nr_full = ((rr_q - ii_q) >>> FRAC_BITS) + PROD_W'(const_real_i);
  assign ni_full = (ri_q >>> (FRAC_BITS - 1)) + PROD_W'(const_imag_i);
  assign zr_d    = sat_val(nr_full);
  assign zi_d    = sat_val(ni_full);

  always_comb begin
    ctl_b_d = ctl_a_q;
    if (!ctl_a_q.done && outside) begin
      ctl_b_d.done    = 1'b1;
      ctl_b_d.escaped = 1'b1;
      ctl_b_d.count   = IDX_COUNT;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_b_q <= '0;
    end else if (en_i) begin
      ctl_b_q <= ctl_b_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      zr_q <= zr_d;
      zi_q <= zi_d;
    end
  end

  assign ctl_o = ctl_b_q;
  assign zr_o  = zr_q;
  assign zi_o  = zi_q;

endmodule

`default_nettype wire

[sv/julia_escape_time_pixel_unit.sv]
// Julia escape-time pixel unit: one pixel per cycle through an unrolled iteration pipeline
// while the output is not stalled. An accepted input beat passes two coordinate stages,
// two stages per iteration and one output register on its way to its output beat.
// Throughput: one pixel per cycle; every iteration has its own multiplier stage.
// A stalled output beat freezes the whole pipeline; the input is ready whenever it moves.
// Reset clears all valid bits and loads the configuration registers with their defaults.
`timescale 1ns / 1ps
`default_nettype none

module julia_escape_time_pixel_unit import jets_pkg::*; #(
  parameter int unsigned ITER_BOUND = ITER_BOUND_DEF
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  jets_pixel_if.sink    pix_i,
  jets_color_if.source  color_o,
  jets_cfg_if.sink      cfg_i
);

  localparam int unsigned LIM_W  = $clog2(ITER_BOUND + 1);
  localparam int unsigned LCMP_W = (MAXIT_W > LIM_W) ? MAXIT_W : LIM_W;

  // Configuration registers.
  logic signed [VAL_W-1:0] start_real_q, start_imag_q, const_real_q, const_imag_q;
  logic [STEP_W-1:0]       step_real_q, step_imag_q;
  logic [RSQ_W-1:0]        radius_sq_q;
  logic [MAXIT_W-1:0]      max_iter_q;

  logic                    en;
  logic [COORD_W-1:0]      cx, cy;
  logic                    s1_valid_q;
  logic [OFFS_W-1:0]       offs_x_q, offs_y_q;
  logic                    s2_valid_q;
  logic signed [VAL_W-1:0] z0r_q, z0i_q;
  logic [LCMP_W-1:0]       mi_ext, lim_wide;
  logic [LIM_W-1:0]        lim;

  jets_ctl_t               chain_ctl [ITER_BOUND+1];
  logic signed [VAL_W-1:0] chain_zr  [ITER_BOUND+1];
  logic signed [VAL_W-1:0] chain_zi  [ITER_BOUND+1];

  logic                    out_valid_q;
  logic [COLOR_W-1:0]      color_q;
  logic                    esc_q;
  logic [COUNT_W-1:0]      count_q;

  // Configuration write port, always ready.
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_real_q <= START_RESET;
      start_imag_q <= START_RESET;
      step_real_q  <= STEP_RESET;
      step_imag_q  <= STEP_RESET;
      const_real_q <= '0;
      const_imag_q <= '0;
      radius_sq_q  <= RADIUS_RESET;
      max_iter_q   <= MAXIT_RESET;
    end else if (cfg_i.valid) begin
      unique case (jets_reg_e'(cfg_i.index))
        REG_START_REAL: start_real_q <= cfg_i.data[VAL_W-1:0];
        REG_START_IMAG: start_imag_q <= cfg_i.data[VAL_W-1:0];
        REG_STEP_REAL:  step_real_q  <= cfg_i.data[STEP_W-1:0];
        REG_STEP_IMAG:  step_imag_q  <= cfg_i.data[STEP_W-1:0];
        REG_CONST_REAL: const_real_q <= cfg_i.data[VAL_W-1:0];
        REG_CONST_IMAG: const_imag_q <= cfg_i.data[VAL_W-1:0];
        REG_RADIUS_SQ:  radius_sq_q  <= cfg_i.data[RSQ_W-1:0];
        REG_MAX_ITER:   max_iter_q   <= cfg_i.data[MAXIT_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective iteration limit, clamped to the range one through ITER_BOUND.
  assign mi_ext = LCMP_W'(max_iter_q);

  always_comb begin
    if (mi_ext == '0) begin
      lim_wide = LCMP_W'(1);
    end else if (mi_ext > LCMP_W'(ITER_BOUND)) begin
      lim_wide = LCMP_W'(ITER_BOUND);
    end else begin
      lim_wide = mi_ext;
    end
  end

  assign lim = lim_wide[LIM_W-1:0];

  // The pipeline moves as a whole unless the output register holds an untaken beat.
  assign en          = !out_valid_q || color_o.ready;
  assign pix_i.ready = en;

  // Stage 1: clamp the coordinates to the image and scale them by the step.
  assign cx = (COORD_W'(pix_i.pixel_x) > COORD_W'(IMAGE_WIDTH)) ?
              COORD_W'(IMAGE_WIDTH) : COORD_W'(pix_i.pixel_x);
  assign cy = (COORD_W'(pix_i.pixel_y) > COORD_W'(IMAGE_HEIGHT)) ?
              COORD_W'(IMAGE_HEIGHT) : COORD_W'(pix_i.pixel_y);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else if (en) begin
      s1_valid_q <= pix_i.valid;
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      offs_x_q <= OFFS_W'(cx) * OFFS_W'(step_real_q);
      offs_y_q <= OFFS_W'(cy) * OFFS_W'(step_imag_q);
    end
  end

  // Stage 2: add the window origin and saturate to form the starting iterate.
  always_ff @(posedge clk_i) begin
    if (en) begin
      z0r_q <= sat_val(PROD_W'(start_real_q) + $signed(PROD_W'(offs_x_q)));
      z0i_q <= sat_val(PROD_W'(start_imag_q) + $signed(PROD_W'(offs_y_q)));
    end
  end

  always_comb begin
    chain_ctl[0]         = '0;
    chain_ctl[0].valid   = s2_valid_q;
  end

  assign chain_zr[0] = z0r_q;
  assign chain_zi[0] = z0i_q;

  // Unrolled iterations, one instance per count.
  for (genvar g = 0; g < ITER_BOUND; g++) begin : g_iter
    jets_iter #(
      .STAGE_IDX (g),
      .LIM_W     (LIM_W)
    ) u_iter (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .en_i         (en),
      .ctl_i        (chain_ctl[g]),
      .zr_i         (chain_zr[g]),
      .zi_i         (chain_zi[g]),
      .const_real_i (const_real_q),
      .const_imag_i (const_imag_q),
      .radius_sq_i  (radius_sq_q),
      .lim_i        (lim),
      .ctl_o        (chain_ctl[g+1]),
      .zr_o         (chain_zr[g+1]),
      .zi_o         (chain_zi[g+1])
    );
  end

  // Output register: palette lookup, black when the point never escaped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= chain_ctl[ITER_BOUND].valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      esc_q   <= chain_ctl[ITER_BOUND].escaped;
      color_q <= chain_ctl[ITER_BOUND].escaped ?
                 palette_color(chain_ctl[ITER_BOUND].count[PAL_IDX_W-1:0]) : '0;
      count_q <= chain_ctl[ITER_BOUND].escaped ? chain_ctl[ITER_BOUND].count : '0;
    end
  end

  assign color_o.valid        = out_valid_q;
  assign color_o.pixel_color  = color_q;
  assign color_o.escaped      = esc_q;
  assign color_o.escape_count = count_q;

  // A frozen pipeline keeps its first stage and its output register unchanged.
  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(s1_valid_q) && $stable(out_valid_q))
    else $error("pipeline moved during an output stall");

  // A point that did not escape comes out black with a zero count.
  a_inside_black: assert property (@(posedge clk_i) disable iff (!rst_ni)
    color_o.valid && !color_o.escaped |-> color_o.pixel_color == '0 &&
                                          color_o.escape_count == '0)
    else $error("non-escaped pixel carries a color or count");

  // Every palette entry is non-black, so an escaped point never reads as black.
  a_escaped_color: assert property (@(posedge clk_i) disable iff (!rst_ni)
    color_o.valid && color_o.escaped |-> color_o.pixel_color != '0)
    else $error("escaped pixel came out black");

  // The effective limit always lies in the supported range.
  a_lim_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lim != '0 && LCMP_W'(lim) <= LCMP_W'(ITER_BOUND))
    else $error("iteration limit out of range");

endmodule

`default_nettype wire
